// ===== hdl/ppu_pkg.sv =====
// shared types, codes and helpers of the particle pool update block
`default_nettype none
package ppu_pkg;

  localparam logic [1:0] FUNC_SPAWN = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAV_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAV_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAV_Z = 2'd2;

  typedef enum logic [1:0] {
    CMD_SPAWN,
    CMD_TICK,
    CMD_CLEAR
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] life;
    logic [47:0] pos;
    logic [47:0] vel;
    logic [47:0] acc;
    logic [31:0] angle_ends;
    logic [63:0] scale_ends;
    logic [63:0] color_ends;
  } cmd_t;

  // fields that a tick only reads
  typedef struct packed {
    logic [15:0] life;
    logic [63:0] color_ends;
    logic [63:0] scale_ends;
    logic [31:0] angle_ends;
    logic [47:0] acc;
  } stat_t;

  // fields that a tick rewrites
  typedef struct packed {
    logic [15:0] age;
    logic [47:0] vel;
    logic [47:0] pos;
  } dyn_t;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [15:0] angle_now;
    logic [15:0] scale_now_x;
    logic [15:0] scale_now_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
  } res_t;

  function automatic logic [15:0] sat16(input logic signed [17:0] x);
    logic [15:0] r;
    if (x > 18'sd32767) begin
      r = 16'h7fff;
    end else if (x < -18'sd32768) begin
      r = 16'h8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ppu_if.sv =====
// request and result channel interfaces
`default_nettype none
interface ppu_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [15:0]        life_frames;
  logic [47:0]        start_position;
  logic [47:0]        start_velocity;
  logic [47:0]        acceleration;
  logic signed [15:0] angle_from;
  logic signed [15:0] angle_to;
  logic [31:0]        start_scale;
  logic [31:0]        end_scale;
  logic [31:0]        start_color;
  logic [31:0]        end_color;
  modport source (output valid, func, life_frames, start_position, start_velocity,
                  acceleration, angle_from, angle_to, start_scale, end_scale,
                  start_color, end_color, input ready);
  modport sink (input valid, func, life_frames, start_position, start_velocity,
                acceleration, angle_from, angle_to, start_scale, end_scale,
                start_color, end_color, output ready);
endinterface

interface ppu_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] angle_now;
  logic [15:0]        scale_now_x;
  logic [15:0]        scale_now_y;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [7:0]         alpha;
  logic               last_of_run;
  modport source (output valid, pos_x, pos_y, pos_z, angle_now, scale_now_x,
                  scale_now_y, red, green, blue, alpha, last_of_run, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, angle_now, scale_now_x,
                scale_now_y, red, green, blue, alpha, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== hdl/ppu_ram.sv =====
// generic single-write ram with registered read
`default_nettype none
module ppu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// ===== hdl/ppu_front.sv =====
// request decode and two-entry command queue
`default_nettype none
module ppu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  ppu_req_if.sink       req_i,
  output ppu_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i
);
  ppu_pkg::cmd_t  mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           known;
  ppu_pkg::cmd_e  op;
  ppu_pkg::cmd_t  item;
  logic           push, pop;

  always_comb begin
    known = 1'b1;
    op    = ppu_pkg::CMD_TICK;
    unique case (req_i.func)
      ppu_pkg::FUNC_SPAWN: op = ppu_pkg::CMD_SPAWN;
      ppu_pkg::FUNC_TICK:  op = ppu_pkg::CMD_TICK;
      ppu_pkg::FUNC_CLEAR: op = ppu_pkg::CMD_CLEAR;
      default:             known = 1'b0;
    endcase
  end

  always_comb begin
    item.cmd        = op;
    item.life       = req_i.life_frames;
    item.pos        = req_i.start_position;
    item.vel        = req_i.start_velocity;
    item.acc        = req_i.acceleration;
    item.angle_ends = {req_i.angle_to, req_i.angle_from};
    item.scale_ends = {req_i.end_scale, req_i.start_scale};
    item.color_ends = {req_i.end_color, req_i.start_color};
  end

  assign req_i.ready = (cnt_q != 2'd2);
  // unused codes are taken and dropped here
  assign push        = req_i.valid & req_i.ready & known;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o & cmd_ready_i;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
    end
  end
endmodule
`default_nettype wire

// ===== hdl/ppu_back.sv =====
// particle store, tick walk, interpolation and result register
`default_nettype none
module ppu_back #(
  parameter int unsigned POOL_SIZE = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ppu_pkg::cmd_t                    cmd_i,
  input  logic                             cmd_valid_i,
  output logic                             cmd_ready_o,
  input  logic                             cfg_we_i,
  input  logic [ppu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ppu_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  ppu_rsp_if.source                        rsp_o
);
  localparam int unsigned AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int unsigned SW = $clog2(POOL_SIZE + 1);
  localparam logic [SW-1:0] NONE = SW'(POOL_SIZE);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SCAN  = 4'd1;
  localparam logic [3:0] ST_WALK  = 4'd2;
  localparam logic [3:0] ST_EVAL  = 4'd3;
  localparam logic [3:0] ST_MUL   = 4'd4;
  localparam logic [3:0] ST_DIV   = 4'd5;
  localparam logic [3:0] ST_ACC   = 4'd6;
  localparam logic [3:0] ST_EMIT  = 4'd7;
  localparam logic [3:0] ST_FLUSH = 4'd8;

  localparam logic [2:0] LERP_ANGLE   = 3'd0;
  localparam logic [2:0] LERP_SCALE_X = 3'd1;
  localparam logic [2:0] LERP_SCALE_Y = 3'd2;
  localparam logic [2:0] LERP_RED     = 3'd3;
  localparam logic [2:0] LERP_GREEN   = 3'd4;
  localparam logic [2:0] LERP_BLUE    = 3'd5;
  localparam logic [2:0] LERP_ALPHA   = 3'd6;

  logic [3:0]           state_q, state_d;
  logic [POOL_SIZE-1:0] live_q, live_d;
  logic [SW-1:0]        newest_q, newest_d, cur_q, cur_d, prev_q, prev_d;
  logic [SW-1:0]        scan_q, scan_d;
  ppu_pkg::cmd_t        cmd_q, cmd_d;
  logic [15:0]          grav_x_q, grav_y_q, grav_z_q;
  logic [15:0]          age_q, age_d;
  logic [2:0]           k_q, k_d;
  logic [15:0]          rem_q, rem_d, quo_q, quo_d;
  logic [3:0]           step_q, step_d;
  logic                 neg_q, neg_d;
  logic signed [16:0]   base_q, base_d;
  ppu_pkg::res_t        res_q, res_d, pend_q, pend_d, out_q, out_d;
  logic                 pend_valid_q, pend_valid_d;
  logic                 out_valid_q, out_valid_d, out_last_q, out_last_d;

  logic                 ram_re;
  logic                 stat_we, dyn_we, ord_we;
  logic [AW-1:0]        dyn_waddr, ord_waddr;
  ppu_pkg::stat_t       stat_wdata, stat_rdata;
  ppu_pkg::dyn_t        dyn_wdata, dyn_rdata, dyn_upd;
  logic [SW-1:0]        ord_wdata, ord_rdata;

  logic [16:0]          age_inc;
  logic signed [16:0]   op_s, op_e;
  logic signed [17:0]   diff, qn, val;
  logic [15:0]          mag;
  logic [31:0]          prod;
  logic [16:0]          dstep;
  logic                 dge;
  logic                 out_free;
  logic [15:0]          gsel [3];

  ppu_ram #(.WIDTH($bits(ppu_pkg::stat_t)), .DEPTH(POOL_SIZE)) u_stat_ram (
    .clk_i, .we_i(stat_we), .waddr_i(scan_q[AW-1:0]), .wdata_i(stat_wdata),
    .re_i(ram_re), .raddr_i(cur_q[AW-1:0]), .rdata_o(stat_rdata)
  );

  ppu_ram #(.WIDTH($bits(ppu_pkg::dyn_t)), .DEPTH(POOL_SIZE)) u_dyn_ram (
    .clk_i, .we_i(dyn_we), .waddr_i(dyn_waddr), .wdata_i(dyn_wdata),
    .re_i(ram_re), .raddr_i(cur_q[AW-1:0]), .rdata_o(dyn_rdata)
  );

  ppu_ram #(.WIDTH(SW), .DEPTH(POOL_SIZE)) u_ord_ram (
    .clk_i, .we_i(ord_we), .waddr_i(ord_waddr), .wdata_i(ord_wdata),
    .re_i(ram_re), .raddr_i(cur_q[AW-1:0]), .rdata_o(ord_rdata)
  );

  assign gsel[0] = grav_x_q;
  assign gsel[1] = grav_y_q;
  assign gsel[2] = grav_z_q;

  // euler step per axis
  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [17:0] vsum, psum;
    logic [15:0]        nv;
    assign vsum = 18'(signed'(dyn_rdata.vel[16*a +: 16]))
                + 18'(signed'(stat_rdata.acc[16*a +: 16]))
                + 18'(signed'(gsel[a]));
    assign nv   = ppu_pkg::sat16(vsum);
    assign psum = 18'(signed'(dyn_rdata.pos[16*a +: 16])) + 18'(signed'(nv));
    assign dyn_upd.vel[16*a +: 16] = nv;
    assign dyn_upd.pos[16*a +: 16] = ppu_pkg::sat16(psum);
  end
  assign age_inc     = {1'b0, dyn_rdata.age} + 17'd1;
  assign dyn_upd.age = age_inc[15:0];

  // lerp operands
  always_comb begin
    op_s = '0;
    op_e = '0;
    case (k_q)
      LERP_ANGLE: begin
        op_s = 17'(signed'(stat_rdata.angle_ends[15:0]));
        op_e = 17'(signed'(stat_rdata.angle_ends[31:16]));
      end
      LERP_SCALE_X: begin
        op_s = {1'b0, stat_rdata.scale_ends[15:0]};
        op_e = {1'b0, stat_rdata.scale_ends[47:32]};
      end
      LERP_SCALE_Y: begin
        op_s = {1'b0, stat_rdata.scale_ends[31:16]};
        op_e = {1'b0, stat_rdata.scale_ends[63:48]};
      end
      LERP_RED: begin
        op_s = {9'b0, stat_rdata.color_ends[7:0]};
        op_e = {9'b0, stat_rdata.color_ends[39:32]};
      end
      LERP_GREEN: begin
        op_s = {9'b0, stat_rdata.color_ends[15:8]};
        op_e = {9'b0, stat_rdata.color_ends[47:40]};
      end
      LERP_BLUE: begin
        op_s = {9'b0, stat_rdata.color_ends[23:16]};
        op_e = {9'b0, stat_rdata.color_ends[55:48]};
      end
      default: begin
        op_s = {9'b0, stat_rdata.color_ends[31:24]};
        op_e = {9'b0, stat_rdata.color_ends[63:56]};
      end
    endcase
  end

  assign diff  = 18'(op_e) - 18'(op_s);
  assign mag   = diff[17] ? 16'(-diff) : diff[15:0];
  assign prod  = {16'b0, mag} * {16'b0, age_q};
  assign dstep = {rem_q, quo_q[15]};
  assign dge   = (dstep >= {1'b0, stat_rdata.life});
  assign qn    = neg_q ? -$signed({2'b0, quo_q}) : $signed({2'b0, quo_q});
  assign val   = 18'(base_q) + qn;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign cmd_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    live_d       = live_q;
    newest_d     = newest_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    scan_d       = scan_q;
    cmd_d        = cmd_q;
    age_d        = age_q;
    k_d          = k_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    step_d       = step_q;
    neg_d        = neg_q;
    base_d       = base_q;
    res_d        = res_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    ram_re       = 1'b0;
    stat_we      = 1'b0;
    dyn_we       = 1'b0;
    ord_we       = 1'b0;
    dyn_waddr    = cur_q[AW-1:0];
    ord_waddr    = prev_q[AW-1:0];
    ord_wdata    = ord_rdata;
    stat_wdata   = '{life: cmd_q.life, color_ends: cmd_q.color_ends,
                     scale_ends: cmd_q.scale_ends, angle_ends: cmd_q.angle_ends,
                     acc: cmd_q.acc};
    dyn_wdata    = dyn_upd;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          case (cmd_i.cmd)
            ppu_pkg::CMD_SPAWN: begin
              scan_d  = '0;
              state_d = ST_SCAN;
            end
            ppu_pkg::CMD_TICK: begin
              cur_d        = newest_q;
              prev_d       = NONE;
              pend_valid_d = 1'b0;
              state_d      = ST_WALK;
            end
            default: begin
              live_d   = '0;
              newest_d = NONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_q == NONE) begin
          state_d = ST_IDLE;
        end else if (!live_q[scan_q[AW-1:0]]) begin
          stat_we   = 1'b1;
          dyn_we    = 1'b1;
          ord_we    = 1'b1;
          dyn_waddr = scan_q[AW-1:0];
          ord_waddr = scan_q[AW-1:0];
          ord_wdata = newest_q;
          dyn_wdata = '{age: 16'd0, vel: cmd_q.vel, pos: cmd_q.pos};
          live_d[scan_q[AW-1:0]] = 1'b1;
          newest_d  = scan_q;
          state_d   = ST_IDLE;
        end else begin
          scan_d = SW'(scan_q + 1'b1);
        end
      end
      ST_WALK: begin
        if (cur_q == NONE) begin
          state_d = ST_FLUSH;
        end else begin
          ram_re  = 1'b1;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (age_inc > {1'b0, stat_rdata.life}) begin
          live_d[cur_q[AW-1:0]] = 1'b0;
          if (prev_q == NONE) begin
            newest_d = ord_rdata;
          end else begin
            ord_we = 1'b1;
          end
          cur_d   = ord_rdata;
          state_d = ST_WALK;
        end else begin
          dyn_we          = 1'b1;
          age_d           = age_inc[15:0];
          res_d.pos_x     = dyn_upd.pos[15:0];
          res_d.pos_y     = dyn_upd.pos[31:16];
          res_d.pos_z     = dyn_upd.pos[47:32];
          prev_d          = cur_q;
          cur_d           = ord_rdata;
          k_d             = LERP_ANGLE;
          state_d         = ST_MUL;
        end
      end
      ST_MUL: begin
        rem_d   = prod[31:16];
        quo_d   = prod[15:0];
        neg_d   = diff[17];
        base_d  = op_s;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d  = dge ? 16'(dstep - {1'b0, stat_rdata.life}) : dstep[15:0];
        quo_d  = {quo_q[14:0], dge};
        step_d = 4'(step_q + 1'b1);
        if (step_q == 4'd15) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        case (k_q)
          LERP_ANGLE:   res_d.angle_now   = val[15:0];
          LERP_SCALE_X: res_d.scale_now_x = val[15:0];
          LERP_SCALE_Y: res_d.scale_now_y = val[15:0];
          LERP_RED:     res_d.red         = val[7:0];
          LERP_GREEN:   res_d.green       = val[7:0];
          LERP_BLUE:    res_d.blue        = val[7:0];
          default:      res_d.alpha       = val[7:0];
        endcase
        if (k_q == LERP_ALPHA) begin
          state_d = ST_EMIT;
        end else begin
          k_d     = 3'(k_q + 1'b1);
          state_d = ST_MUL;
        end
      end
      ST_EMIT: begin
        if (!pend_valid_q) begin
          pend_d       = res_q;
          pend_valid_d = 1'b1;
          state_d      = ST_WALK;
        end else if (out_free) begin
          out_d       = pend_q;
          out_last_d  = 1'b0;
          out_valid_d = 1'b1;
          pend_d      = res_q;
          state_d     = ST_WALK;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_d        = pend_q;
          out_last_d   = 1'b1;
          out_valid_d  = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    age_q      <= age_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    neg_q      <= neg_d;
    base_q     <= base_d;
    res_q      <= res_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      live_q       <= '0;
      newest_q     <= NONE;
      cur_q        <= NONE;
      prev_q       <= NONE;
      scan_q       <= '0;
      k_q          <= LERP_ANGLE;
      step_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      grav_x_q     <= '0;
      grav_y_q     <= '0;
      grav_z_q     <= '0;
    end else begin
      state_q      <= state_d;
      live_q       <= live_d;
      newest_q     <= newest_d;
      cur_q        <= cur_d;
      prev_q       <= prev_d;
      scan_q       <= scan_d;
      k_q          <= k_d;
      step_q       <= step_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ppu_pkg::CFG_GRAV_X: grav_x_q <= cfg_data_i;
          ppu_pkg::CFG_GRAV_Y: grav_y_q <= cfg_data_i;
          ppu_pkg::CFG_GRAV_Z: grav_z_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.pos_x       = out_q.pos_x;
  assign rsp_o.pos_y       = out_q.pos_y;
  assign rsp_o.pos_z       = out_q.pos_z;
  assign rsp_o.angle_now   = out_q.angle_now;
  assign rsp_o.scale_now_x = out_q.scale_now_x;
  assign rsp_o.scale_now_y = out_q.scale_now_y;
  assign rsp_o.red         = out_q.red;
  assign rsp_o.green       = out_q.green;
  assign rsp_o.blue        = out_q.blue;
  assign rsp_o.alpha       = out_q.alpha;
  assign rsp_o.last_of_run = out_last_q;
endmodule
`default_nettype wire

// ===== hdl/particle_pool_update.sv =====
// top level of the particle pool update block
//
//   channel   dir   handshake              contents
//   req_i     in    valid/ready            func, lifetime, motion, start/end looks
//   rsp_o     out   valid/ready            updated position and interpolated looks
//   cfg       in    cfg_we_i, no wait      gravity x/y/z at cfg_idx_i
//
// spawn: a scan over the live bits from slot 0 takes the first free slot
// tick: an expired particle is unlinked; for each survivor seven lerps
//   share one 16x16 multiplier and a radix-2 divider of 16 steps each
// clear: drops every live bit; a two-entry request queue runs ahead of the executing part
// no clearing pass after reset; a stalled result holds the walk at its emit
`default_nettype none
module particle_pool_update #(
  parameter int unsigned POOL_SIZE = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ppu_req_if.sink                        req_i,
  ppu_rsp_if.source                      rsp_o,
  input  logic                           cfg_we_i,
  input  logic [ppu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ppu_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  ppu_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_ready;

  ppu_front u_front (
    .clk_i, .rst_ni, .req_i,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready)
  );

  ppu_back #(.POOL_SIZE(POOL_SIZE)) u_back (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .rsp_o
  );
endmodule
`default_nettype wire
